### hdl/lte_pkg.sv
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types and constants of the terminal line editor.
// ----------------------------------------------------------------------------
package lte_pkg;

  // store depth, and the hard limit on the line capacity
  localparam int LINE_MAX  = 64;
  localparam int HARD_CAP  = 64;
  localparam int CAP_LIMIT = (LINE_MAX < HARD_CAP) ? LINE_MAX : HARD_CAP;
  localparam int ADDR_W    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 7;
  localparam int ACT_W  = 2;

  localparam logic [CFG_W-1:0] MAX_LENGTH_RST = CFG_W'(64);

  localparam logic [CHAR_W-1:0] KEY_BS    = CHAR_W'(8);
  localparam logic [CHAR_W-1:0] KEY_LF    = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] KEY_CR    = CHAR_W'(13);
  localparam logic [CHAR_W-1:0] KEY_SPACE = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] KEY_DEL   = CHAR_W'(127);

  typedef enum logic [ACT_W-1:0] {
    ACT_CHAR  = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_RIGHT = 2'd2
  } action_e;

  typedef enum logic {
    EV_REDRAW = 1'b0,
    EV_COMMIT = 1'b1
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_KEY,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_STR_RD,
    ST_STR_OUT
  } state_e;

  typedef struct packed {
    logic              event_res;
    logic [POS_W-1:0]  line_length;
    logic [POS_W-1:0]  previous_length;
    logic [POS_W-1:0]  cursor_position;
    logic [POS_W-1:0]  char_index;
    logic [CHAR_W-1:0] char_value;
    logic              has_char;
    logic              last;
  } res_t;

endpackage

### hdl/lte_ram.sv
// ----------------------------------------------------------------------------
// lte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/lte_seq.sv
// ----------------------------------------------------------------------------
// lte_seq
// Edit sequencer: decodes a key, moves the line tail one character per step
// through the store port, then streams the line out.
// ----------------------------------------------------------------------------
module lte_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lte_pkg::ACT_W-1:0]   action_i,
  input  logic [lte_pkg::CHAR_W-1:0]  key_code_i,
  input  logic [lte_pkg::CFG_W-1:0]   cap_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lte_pkg::res_t               res_o
);
  import lte_pkg::*;

  state_e            state_q, state_d;
  logic [ACT_W-1:0]  act_q, act_d;
  logic [CHAR_W-1:0] key_q, key_d;
  logic [POS_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  cur_q, cur_d;
  logic [POS_W-1:0]  drawn_q, drawn_d;
  logic [POS_W-1:0]  prev_q, prev_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic              ev_q, ev_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic [POS_W:0]    idx_inc;
  logic              has_char;
  logic              last;
  logic              printable;
  logic              room;

  lte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx_inc   = {1'b0, idx_q} + (POS_W+1)'(1);
  assign has_char  = (len_q != '0);
  assign last      = !has_char || (idx_inc == {1'b0, len_q});
  assign printable = (key_q >= KEY_SPACE) && (key_q < KEY_DEL);
  assign room      = (({1'b0, len_q} + CFG_W'(1)) < cap_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      drawn_q <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      drawn_q <= drawn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    key_q  <= key_d;
    prev_q <= prev_d;
    idx_q  <= idx_d;
    ev_q   <= ev_d;
  end

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    key_d     = key_q;
    len_d     = len_q;
    cur_d     = cur_q;
    drawn_d   = drawn_q;
    prev_d    = prev_q;
    idx_d     = idx_q;
    ev_d      = ev_q;
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(idx_q);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(idx_q);
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          act_d   = action_i;
          key_d   = key_code_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        prev_d  = drawn_q;
        ev_d    = EV_REDRAW;
        idx_d   = '0;
        state_d = ST_IDLE;
        unique case (act_q)
          ACT_LEFT: begin
            if (cur_q != '0) begin
              cur_d   = cur_q - POS_W'(1);
              state_d = ST_STR_RD;
            end
          end
          ACT_RIGHT: begin
            if (cur_q < len_q) begin
              cur_d   = cur_q + POS_W'(1);
              state_d = ST_STR_RD;
            end
          end
          ACT_CHAR: begin
            if (key_q == KEY_LF || key_q == KEY_CR) begin
              ev_d    = EV_COMMIT;
              state_d = ST_STR_RD;
            end else if (key_q == KEY_BS) begin
              if (cur_q != '0) begin
                idx_d   = cur_q - POS_W'(1);
                state_d = ST_DEL_RD;
              end
            end else if (printable && room) begin
              idx_d   = len_q;
              state_d = ST_INS_RD;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      // tail moves right, from the end down to the cursor
      ST_INS_RD: begin
        if (idx_q > cur_q) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(idx_q - POS_W'(1));
          state_d   = ST_INS_WR;
        end else begin
          state_d = ST_INS_KEY;
        end
      end

      ST_INS_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_q - POS_W'(1);
        state_d = ST_INS_RD;
      end

      ST_INS_KEY: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(cur_q);
        ram_wdata = key_q;
        cur_d     = cur_q + POS_W'(1);
        len_d     = len_q + POS_W'(1);
        drawn_d   = len_q + POS_W'(1);
        idx_d     = '0;
        state_d   = ST_STR_RD;
      end

      // tail moves left, from the cursor up to the end
      ST_DEL_RD: begin
        if (idx_inc < {1'b0, len_q}) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(idx_inc);
          state_d   = ST_DEL_WR;
        end else begin
          cur_d   = cur_q - POS_W'(1);
          len_d   = len_q - POS_W'(1);
          drawn_d = len_q - POS_W'(1);
          idx_d   = '0;
          state_d = ST_STR_RD;
        end
      end

      ST_DEL_WR: begin
        ram_we  = 1'b1;
        idx_d   = POS_W'(idx_inc);
        state_d = ST_DEL_RD;
      end

      ST_STR_RD: begin
        ram_re  = 1'b1;
        state_d = ST_STR_OUT;
      end

      ST_STR_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (last) begin
            state_d = ST_IDLE;
            if (ev_q == EV_COMMIT) begin
              len_d   = '0;
              cur_d   = '0;
              drawn_d = '0;
            end
          end else begin
            idx_d   = POS_W'(idx_inc);
            state_d = ST_STR_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.event_res       = ev_q;
    res_o.line_length     = len_q;
    res_o.previous_length = prev_q;
    res_o.cursor_position = cur_q;
    res_o.char_index      = idx_q;
    res_o.char_value      = has_char ? ram_rdata : '0;
    res_o.has_char        = has_char;
    res_o.last            = last;
  end

  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond line end");

  a_len_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, len_q} < CFG_W'(CAP_LIMIT))
    else $error("line length reached capacity");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last) |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after final transfer");

  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last && ev_q == EV_COMMIT)
      |=> (len_q == '0 && cur_q == '0 && drawn_q == '0))
    else $error("commit left editing state");

endmodule

### hdl/terminal_line_editor_top.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_top
// Line editor: inserts, deletes and moves the cursor in one stored line and
// streams the line out on a redraw or a commit, one character per transfer.
// ----------------------------------------------------------------------------
// a key with no effect is decoded and dropped; otherwise the key is decoded,
//   each character moved in the store is read and then written, then the key
//   is written on an insert or the delete is closed, then each character is
//   read and streamed (1 item for an empty line)
// one key at a time: the input stalls until the sequencer is back in idle
// reset: line empty, cursor 0, capacity 64; store contents stay undefined
// ----------------------------------------------------------------------------
module terminal_line_editor_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lte_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lte_pkg::ACT_W-1:0]   action_i,
  input  logic [lte_pkg::CHAR_W-1:0]  key_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        event_res_o,
  output logic [lte_pkg::POS_W-1:0]   line_length_o,
  output logic [lte_pkg::POS_W-1:0]   previous_length_o,
  output logic [lte_pkg::POS_W-1:0]   cursor_position_o,
  output logic [lte_pkg::POS_W-1:0]   char_index_o,
  output logic [lte_pkg::CHAR_W-1:0]  char_value_o,
  output logic                        has_char_o,
  output logic                        last_o
);
  import lte_pkg::*;

  logic [CFG_W-1:0] max_length_q;
  logic [CFG_W-1:0] cap;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  // effective capacity is clipped to the smaller of the store depth and the hard cap
  assign cap = (max_length_q > CFG_W'(CAP_LIMIT)) ? CFG_W'(CAP_LIMIT) : max_length_q;

  lte_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .key_code_i  (key_code_i),
    .cap_i       (cap),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign event_res_o       = res.event_res;
  assign line_length_o     = res.line_length;
  assign previous_length_o = res.previous_length;
  assign cursor_position_o = res.cursor_position;
  assign char_index_o      = res.char_index;
  assign char_value_o      = res.char_value;
  assign has_char_o        = res.has_char;
  assign last_o            = res.last;

endmodule
